### rtl/core/piecewise_linear_interpolator_assert.svh
// Assertion macros for the piecewise linear interpolator checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define PLI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; imported by every module of the block.
package pli_pkg;

    // Field widths
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 9;
    localparam int SEG_W      = 9;
    localparam int PIU_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int PROD_W     = 2 * VAL_W;

    // Default table depth
    localparam int MAX_POINTS_DEF = 512;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRAP = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] point_x;
        logic signed [VAL_W-1:0] point_y;
        logic signed [VAL_W-1:0] query_x;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_y;
        logic [SEG_W-1:0]        segment;
        logic                    zero_span;
        logic                    saturated;
    } out_item_t;

endpackage

### rtl/core/pli_table.sv
// Breakpoint storage: x and y memories, one write and one registered read port.
// Depends on pli_pkg.
module pli_table #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [pli_pkg::VAL_W-1:0] wr_x,
    input  logic signed [pli_pkg::VAL_W-1:0] wr_y,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [pli_pkg::VAL_W-1:0] rd_x,
    output logic signed [pli_pkg::VAL_W-1:0] rd_y
);
    import pli_pkg::*;

    logic signed [VAL_W-1:0] x_mem [MAX_POINTS];
    logic signed [VAL_W-1:0] y_mem [MAX_POINTS];
    logic signed [VAL_W-1:0] rd_x_reg;
    logic signed [VAL_W-1:0] rd_y_reg;

    // Write and registered read, no reset on storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    assign rd_x = rd_x_reg;
    assign rd_y = rd_y_reg;

endmodule

### rtl/core/pli_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit unsigned.
// Depends on pli_pkg.
module pli_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pli_pkg::PROD_W-1:0]  dividend,
    input  logic [pli_pkg::VAL_W-1:0]   divisor,
    output logic                        done,
    output logic [pli_pkg::PROD_W-1:0]  quotient
);
    import pli_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic                run_reg,  run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic [VAL_W-1:0]    rem_reg,  rem_next;
    logic [PROD_W-1:0]   quo_reg,  quo_next;
    logic [VAL_W-1:0]    dvs_reg,  dvs_next;
    logic [VAL_W:0]      shifted;
    logic [VAL_W:0]      diff;
    logic                ge;

    // One trial subtract per cycle
    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(PROD_W - 1);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: sequencer, search and result datapath.
// Depends on pli_pkg, pli_table and pli_div.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------
//  item     | in        | start & !busy       | item (in_item_t)
//  result   | out       | done, one cycle     | result (out_item_t)
//  config   | in        | cfg_we              | cfg_index, cfg_wdata
//
// A load transaction leaves busy low.
// A query keeps busy high through a forward walk of 0 to n-2 breakpoints (n the
// points in use), read one breakpoint a cycle from the table port, and through
// the 64 steps of the serial divider. An equal-x segment skips the divider.
// done shows in the first cycle busy is low again.
// Reset clears control state only; the tables hold garbage until loaded.
// The receiver cannot stall: each result is shown for exactly one cycle.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pli_pkg::in_item_t                 item,
    output logic                              done,
    output pli_pkg::out_item_t                result,
    input  logic                              cfg_we,
    input  logic [pli_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pli_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import pli_pkg::*;

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = (AW + 1 > PIU_W) ? AW + 1 : PIU_W;
    localparam int IW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;
    localparam int SW = 43;
    localparam logic signed [SW-1:0] SUM_MAX = 43'sd2147483647;
    localparam logic signed [SW-1:0] SUM_MIN = -43'sd2147483648;
    localparam logic signed [VAL_W-1:0] Y_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] Y_MIN = 32'sh80000000;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LAST   = 10'b0000000010,
        S_WALK   = 10'b0000000100,
        S_RDL    = 10'b0000001000,
        S_RDR    = 10'b0000010000,
        S_PREP   = 10'b0000100000,
        S_MUL    = 10'b0001000000,
        S_DSTART = 10'b0010000000,
        S_DWAIT  = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PIU_W-1:0]        piu_reg,   piu_next;
    logic                    ext_reg,   ext_next;
    logic                    done_reg,  done_next;
    out_item_t               res_reg,   res_next;
    logic signed [VAL_W-1:0] q_reg,     q_next;
    logic [AW-1:0]           nm2_reg,   nm2_next;
    logic [AW-1:0]           cand_reg,  cand_next;
    logic [AW-1:0]           seg_reg,   seg_next;
    logic signed [VAL_W-1:0] xl_reg,    xl_next;
    logic signed [VAL_W-1:0] yl_reg,    yl_next;
    logic signed [VAL_W-1:0] xr_reg,    xr_next;
    logic signed [VAL_W-1:0] yr_reg,    yr_next;
    logic signed [VAL_W-1:0] yl1_reg,   yl1_next;
    logic [VAL_W-1:0]        mdy_reg,   mdy_next;
    logic [VAL_W-1:0]        mdq_reg,   mdq_next;
    logic [VAL_W-1:0]        mdx_reg,   mdx_next;
    logic                    neg_reg,   neg_next;
    logic                    zero_reg,  zero_next;
    logic [PROD_W-1:0]       prod_reg,  prod_next;

    logic                    accept;
    logic [CW-1:0]           piu_w;
    logic [CW-1:0]           n_w;
    logic [AW-1:0]           nm2_w;
    logic [IW-1:0]           ld_idx_w;
    logic                    tbl_we;
    logic [AW-1:0]           tbl_raddr;
    logic signed [VAL_W-1:0] rd_x;
    logic signed [VAL_W-1:0] rd_y;
    logic                    div_start;
    logic                    div_done;
    logic [PROD_W-1:0]       quo;

    logic signed [VAL_W-1:0] yr1_w;
    logic signed [VAL_W-1:0] yl1_w;
    logic signed [VAL_W:0]   dy_w;
    logic signed [VAL_W:0]   dq_w;
    logic signed [VAL_W:0]   dx_w;
    logic [VAL_W:0]          ady_w;
    logic [VAL_W:0]          adq_w;
    logic [VAL_W:0]          adx_w;
    logic                    big_w;
    logic signed [SW-1:0]    yl_ext;
    logic signed [SW-1:0]    mq_ext;
    logic signed [SW-1:0]    sum_w;
    logic [IW-1:0]           seg_ext;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Points in use, clamped to 2..MAX_POINTS
    assign piu_w = CW'(piu_reg);
    assign n_w   = (piu_w < CW'(2)) ? CW'(2) :
                   (piu_w > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : piu_w;
    assign nm2_w = AW'(n_w - CW'(2));

    // Loads beyond the table depth are dropped
    assign ld_idx_w = IW'(item.entry_index);
    assign tbl_we   = accept && (item.kind == KIND_LOAD) && (ld_idx_w < IW'(MAX_POINTS));

    pli_table #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (ld_idx_w[AW-1:0]),
        .wr_x    (item.point_x),
        .wr_y    (item.point_y),
        .rd_addr (tbl_raddr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mdx_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Segment prep: clamp end values, spans and their magnitudes
    assign yr1_w = (!ext_reg && (q_reg < xl_reg)) ? yl_reg : yr_reg;
    assign yl1_w = (!ext_reg && (q_reg > xr_reg)) ? yr1_w : yl_reg;
    assign dy_w  = (VAL_W + 1)'(yr1_w) - (VAL_W + 1)'(yl1_w);
    assign dq_w  = (VAL_W + 1)'(q_reg) - (VAL_W + 1)'(xl_reg);
    assign dx_w  = (VAL_W + 1)'(xr_reg) - (VAL_W + 1)'(xl_reg);
    assign ady_w = dy_w[VAL_W] ? (VAL_W + 1)'(-dy_w) : dy_w;
    assign adq_w = dq_w[VAL_W] ? (VAL_W + 1)'(-dq_w) : dq_w;
    assign adx_w = dx_w[VAL_W] ? (VAL_W + 1)'(-dx_w) : dx_w;

    // Final add: quotients above 2^40 saturate outright
    assign big_w  = (|quo[PROD_W-1:41]) || (quo[40] && (|quo[39:0]));
    assign yl_ext = SW'(yl1_reg);
    assign mq_ext = $signed({2'b00, quo[40:0]});
    assign sum_w  = neg_reg ? (yl_ext - mq_ext) : (yl_ext + mq_ext);
    assign seg_ext = IW'(seg_reg);

    // Sequencer and next-state datapath
    always_comb
    begin
        state_next = state_reg;
        piu_next   = piu_reg;
        ext_next   = ext_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        q_next     = q_reg;
        nm2_next   = nm2_reg;
        cand_next  = cand_reg;
        seg_next   = seg_reg;
        xl_next    = xl_reg;
        yl_next    = yl_reg;
        xr_next    = xr_reg;
        yr_next    = yr_reg;
        yl1_next   = yl1_reg;
        mdy_next   = mdy_reg;
        mdq_next   = mdq_reg;
        mdx_next   = mdx_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        prod_next  = prod_reg;
        tbl_raddr  = '0;
        div_start  = 1'b0;

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_POINTS: piu_next = cfg_wdata[PIU_W-1:0];
                CFG_EXTRAP: ext_next = cfg_wdata[0];
                default:    piu_next = piu_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.kind == KIND_QUERY))
                begin
                    q_next     = item.query_x;
                    nm2_next   = nm2_w;
                    tbl_raddr  = nm2_w;
                    state_next = S_LAST;
                end
            end
            // At or beyond the second-to-last breakpoint takes the last segment
            S_LAST:
            begin
                if ((q_reg >= rd_x) || (nm2_reg == '0))
                begin
                    seg_next   = nm2_reg;
                    tbl_raddr  = nm2_reg;
                    state_next = S_RDL;
                end
                else
                begin
                    cand_next  = AW'(1);
                    tbl_raddr  = AW'(1);
                    state_next = S_WALK;
                end
            end
            // Forward walk, one breakpoint per cycle
            S_WALK:
            begin
                if ((q_reg <= rd_x) || (cand_reg == nm2_reg))
                begin
                    seg_next   = cand_reg - AW'(1);
                    tbl_raddr  = cand_reg - AW'(1);
                    state_next = S_RDL;
                end
                else
                begin
                    cand_next  = cand_reg + AW'(1);
                    tbl_raddr  = cand_reg + AW'(1);
                end
            end
            S_RDL:
            begin
                xl_next    = rd_x;
                yl_next    = rd_y;
                tbl_raddr  = seg_reg + AW'(1);
                state_next = S_RDR;
            end
            S_RDR:
            begin
                xr_next    = rd_x;
                yr_next    = rd_y;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                yl1_next   = yl1_w;
                mdy_next   = ady_w[VAL_W-1:0];
                mdq_next   = adq_w[VAL_W-1:0];
                mdx_next   = adx_w[VAL_W-1:0];
                neg_next   = dy_w[VAL_W] ^ dq_w[VAL_W] ^ dx_w[VAL_W];
                zero_next  = (xr_reg == xl_reg);
                state_next = (xr_reg == xl_reg) ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(mdy_reg) * PROD_W'(mdq_reg);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            // Saturate and present the result
            S_FIN:
            begin
                res_next.segment = seg_ext[SEG_W-1:0];
                if (zero_reg)
                begin
                    res_next.result_y  = yl1_reg;
                    res_next.zero_span = 1'b1;
                    res_next.saturated = 1'b0;
                end
                else if (big_w)
                begin
                    res_next.result_y  = neg_reg ? Y_MIN : Y_MAX;
                    res_next.zero_span = 1'b0;
                    res_next.saturated = 1'b1;
                end
                else if (sum_w > SUM_MAX)
                begin
                    res_next.result_y  = Y_MAX;
                    res_next.zero_span = 1'b0;
                    res_next.saturated = 1'b1;
                end
                else if (sum_w < SUM_MIN)
                begin
                    res_next.result_y  = Y_MIN;
                    res_next.zero_span = 1'b0;
                    res_next.saturated = 1'b1;
                end
                else
                begin
                    res_next.result_y  = sum_w[VAL_W-1:0];
                    res_next.zero_span = 1'b0;
                    res_next.saturated = 1'b0;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            piu_reg   <= PIU_W'(2);
            ext_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            piu_reg   <= piu_next;
            ext_reg   <= ext_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        q_reg    <= q_next;
        nm2_reg  <= nm2_next;
        cand_reg <= cand_next;
        seg_reg  <= seg_next;
        xl_reg   <= xl_next;
        yl_reg   <= yl_next;
        xr_reg   <= xr_next;
        yr_reg   <= yr_next;
        yl1_reg  <= yl1_next;
        mdy_reg  <= mdy_next;
        mdq_reg  <= mdq_next;
        mdx_reg  <= mdx_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        prod_reg <= prod_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

### rtl/core/pli_checker.sv
// Port-level checker for the piecewise linear interpolator, bound to the top level.
// Depends on pli_pkg and piecewise_linear_interpolator_assert.svh.
`include "piecewise_linear_interpolator_assert.svh"

module pli_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input pli_pkg::in_item_t   item,
    input logic                done,
    input pli_pkg::out_item_t  result
);
    import pli_pkg::*;

    // A result only follows a query in flight
    `PLI_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result strobe without busy before it")

    // Strobe lasts one cycle
    `PLI_ASSERT_NEXT(a_done_single, done, !done, "result strobe held more than one cycle")

    // A query occupies the block
    `PLI_ASSERT_NEXT(a_query_busy, start && !busy && item.kind == KIND_QUERY, busy, "query transaction did not raise busy")

    // A load neither occupies the block nor yields a result
    `PLI_ASSERT_NEXT(a_load_idle, start && !busy && item.kind == KIND_LOAD, !busy && !done, "load transaction raised busy or a result")

    // Equal-x segments never report clipping
    `PLI_ASSERT_SAME(a_zero_no_sat, done && result.zero_span, !result.saturated, "zero span result flagged as saturated")

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);
